@@ sv/assert_macros.svh @@
// Assertion macros shared by the limiter RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ sv/slpl_pkg.sv @@
// Package for the stereo lookahead peak limiter: constants, types, helpers.
// No dependencies.
package slpl_pkg;
    localparam int SW = 24;   // sample width
    localparam int WW = 28;   // filter / delay width
    localparam int GW = 25;   // gain width
    localparam int CW = 24;   // coefficient width

    localparam logic [GW-1:0] ONE_Q24 = 25'd16777216;
    localparam logic [WW-1:0] THRESH_Q23 = 28'd8262779;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_HP     = 3'd1;
    localparam logic [2:0] REG_REL    = 3'd2;
    localparam logic [2:0] REG_HEAD   = 3'd3;
    localparam logic [2:0] REG_LA     = 3'd4;

    typedef logic signed [SW-1:0] t_sample;
    typedef logic signed [WW-1:0] t_wide;

    // lane control from sequencer
    typedef struct packed {
        logic start_hp;   // latch filter product
        logic start_sc;   // latch scaled sample
        logic clear;      // reset filter state
    } t_lane_ctl;

    // floor((p + 2^23) / 2^24) for a signed product
    function automatic logic signed [63:0] rnd24(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd8388608;
        return t >>> 24;
    endfunction

    function automatic t_wide sat28(input logic signed [63:0] v);
        if (v > 64'sd134217727) return 28'sh7FFFFFF;
        if (v < -64'sd134217728) return 28'sh8000000;
        return v[WW-1:0];
    endfunction

    function automatic t_sample sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[SW-1:0];
    endfunction
endpackage

@@ sv/slpl_if.sv @@
// Valid/ready stream interfaces for the limiter: sample items and config writes.
// Depends on slpl_pkg.
interface slpl_stream_if;
    logic valid;
    logic ready;
    slpl_pkg::t_sample left;
    slpl_pkg::t_sample right;
    modport source(output valid, output left, output right, input ready);
    modport sink(input valid, input left, input right, output ready);
endinterface

interface slpl_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [24:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

@@ sv/slpl_lane.sv @@
// One channel lane: high-pass filter, headroom scale, output gain multiply.
// Depends on slpl_pkg; steps set by the sequencer in the top level.
module slpl_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slpl_pkg::t_lane_ctl  i_ctl,
    input  slpl_pkg::t_sample    i_x,
    input  logic [23:0]          i_hp_coeff,
    input  logic [24:0]          i_head,
    input  logic [27:0]          i_dly,
    input  logic [24:0]          i_dgain,
    output slpl_pkg::t_wide      o_scaled,
    output slpl_pkg::t_sample    o_out
);
    import slpl_pkg::*;

    logic signed [23:0] r_last_in;
    t_wide              r_last_out;
    t_wide              r_scaled;
    logic signed [63:0] hp_prod, sc_prod, out_prod;
    logic signed [63:0] sc_rnd;
    t_wide              n_y;

    // one multiply per step
    assign hp_prod = $signed({40'd0, i_hp_coeff}) * 64'(r_last_out);
    assign n_y = sat28(64'(i_x) - 64'(r_last_in) + rnd24(hp_prod));
    assign sc_prod = 64'(r_last_out) * $signed({39'd0, i_head});
    assign sc_rnd = rnd24(sc_prod);
    assign out_prod = 64'($signed(i_dly)) * $signed({39'd0, i_dgain});

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_last_in  <= '0;
            r_last_out <= '0;
        end else if (i_ctl.start_hp) begin
            r_last_in  <= i_x;
            r_last_out <= n_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start_sc) begin
            r_scaled <= sc_rnd[WW-1:0];
        end
    end

    assign o_scaled = r_scaled;
    assign o_out = sat24(rnd24(out_prod));
endmodule

@@ sv/slpl_div.sv @@
// Restoring divider for the limiter gain: round(THRESH*2^24 / env), one bit per cycle.
// Depends on slpl_pkg.
module slpl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [27:0] i_den,
    output logic        o_busy,
    output logic [24:0] o_quot
);
    import slpl_pkg::*;

    // numerator 8262779*2^24 + env/2 fits 48 bits; quotient < 2^25
    logic [47:0] r_num;
    logic [28:0] r_rem;
    logic [24:0] r_q;
    logic [27:0] r_den;
    logic [5:0]  r_cnt;
    logic [28:0] n_trial;
    logic [47:0] num0;

    assign num0 = {THRESH_Q23[23:0], 24'd0} + 48'(i_den >> 1);
    assign n_trial = {r_rem[27:0], r_num[47]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd48;
            r_num <= num0;
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
            r_num <= {r_num[46:0], 1'b0};
            if (n_trial >= {1'b0, r_den}) begin
                r_rem <= n_trial - {1'b0, r_den};
                r_q   <= {r_q[23:0], 1'b1};
            end else begin
                r_rem <= n_trial;
                r_q   <= {r_q[23:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_quot = r_q;
endmodule

@@ sv/stereo_lookahead_peak_limiter.sv @@
// Stereo lookahead peak limiter top: sequencer, two lanes, envelope, divider, delay.
// Disabled, an item goes to the output register in S_PASS. Enabled, it runs S_HP, S_SC,
// S_ENV, S_REL, S_DIV, S_HOLD, S_WR, S_RD, S_OUT; S_HOLD waits while the divider, which
// starts only when the envelope is above threshold, runs. Input waits until the result
// is taken. Synchronous active-low reset clears control and filter state; delay entries
// are undefined until written. Depends on slpl_pkg, slpl_if, slpl_lane, slpl_div.
module stereo_lookahead_peak_limiter #(
    parameter int DELAY_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slpl_stream_if.sink   i_in,
    slpl_stream_if.source o_out,
    slpl_cfg_if.sink      i_cfg
);
    import slpl_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam logic [AW:0] LA_MAX = (AW+1)'(DELAY_DEPTH - 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_HP = 4'd1, S_SC = 4'd2, S_ENV = 4'd3,
                           S_REL = 4'd4, S_DIV = 4'd5, S_WR = 4'd6, S_RD = 4'd7,
                           S_OUT = 4'd8, S_PASS = 4'd9, S_HOLD = 4'd10;

    logic [3:0]  r_state, n_state;
    logic        r_enable;
    logic [23:0] r_hp, r_rel;
    logic [24:0] r_head;
    logic [7:0]  r_la;
    t_sample     r_xl, r_xr;
    logic [27:0] r_env, r_p;
    logic [AW-1:0] r_wi, r_ri;
    logic        r_primed, r_emit;
    t_sample     r_ol, r_or;
    logic        r_ovalid;

    logic [27:0] mem_l [DELAY_DEPTH];
    logic [27:0] mem_r [DELAY_DEPTH];
    logic [24:0] mem_g [DELAY_DEPTH];
    logic [27:0] r_dl, r_dr;
    logic [24:0] r_dg;

    t_lane_ctl ctl;
    t_wide     sl, sr;
    t_sample   lo, ro;
    logic      div_busy, div_start;
    logic [24:0] quot, head_eff;
    logic [27:0] al, ar, pk;
    logic signed [63:0] rel_prod, rel_rnd;
    logic      cfg_clear;
    logic [AW:0] wi_next, la_eff;

    assign cfg_clear = i_cfg.valid && i_cfg.ready && i_cfg.index == REG_ENABLE
                       && !i_cfg.data[0];
    assign head_eff = (r_head > ONE_Q24) ? ONE_Q24 : r_head;

    assign ctl.start_hp = (r_state == S_HP);
    assign ctl.start_sc = (r_state == S_SC);
    assign ctl.clear    = cfg_clear;

    slpl_lane u_left (.i_clk, .i_rst_n, .i_ctl(ctl), .i_x(r_xl), .i_hp_coeff(r_hp),
        .i_head(head_eff), .i_dly(r_dl), .i_dgain(r_dg), .o_scaled(sl), .o_out(lo));
    slpl_lane u_right (.i_clk, .i_rst_n, .i_ctl(ctl), .i_x(r_xr), .i_hp_coeff(r_hp),
        .i_head(head_eff), .i_dly(r_dr), .i_dgain(r_dg), .o_scaled(sr), .o_out(ro));

    // gain divide only when the new envelope is above threshold
    assign div_start = (r_state == S_DIV) && (r_env > THRESH_Q23);

    slpl_div u_div (.i_clk, .i_rst_n, .i_start(div_start), .i_den(r_env),
        .o_busy(div_busy), .o_quot(quot));

    // merge stage: peak of both lanes
    assign al = sl[WW-1] ? 28'(-sl) : 28'(sl);
    assign ar = sr[WW-1] ? 28'(-sr) : 28'(sr);
    assign pk = (al > ar) ? al : ar;
    assign rel_prod = $signed({40'd0, r_rel}) * $signed({36'd0, r_env - r_p});
    assign rel_rnd = rnd24(rel_prod);

    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_in.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.left  = r_ol;
    assign o_out.right = r_or;

    assign wi_next = (32'(r_wi) + 1 >= DELAY_DEPTH) ? '0 : (AW+1)'(r_wi) + 1'b1;
    assign la_eff  = (int'(r_la) > DELAY_DEPTH - 1) ? LA_MAX : (AW+1)'(r_la);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid && i_in.ready) n_state = r_enable ? S_HP : S_PASS;
            S_HP:    n_state = S_SC;
            S_SC:    n_state = S_ENV;
            S_ENV:   n_state = S_REL;
            S_REL:   n_state = S_DIV;
            S_DIV:   n_state = S_HOLD;
            S_HOLD:  if (!div_busy) n_state = S_WR;
            S_WR:    n_state = S_RD;
            S_RD:    n_state = S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // delay memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            mem_l[r_wi] <= sl;
            mem_r[r_wi] <= sr;
            mem_g[r_wi] <= (r_env > THRESH_Q23) ? quot : ONE_Q24;
        end
        if (r_state == S_RD) begin
            r_dl <= mem_l[r_ri];
            r_dr <= mem_r[r_ri];
            r_dg <= mem_g[r_ri];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_enable <= 1'b0;
            r_hp     <= 24'd16737733;
            r_rel    <= 24'd16773104;
            r_head   <= ONE_Q24;
            r_la     <= 8'd168;
            r_env    <= '0;
            r_wi     <= '0;
            r_ri     <= '0;
            r_primed <= 1'b0;
            r_ovalid <= 1'b0;
            r_emit   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_ENABLE: r_enable <= i_cfg.data[0];
                    REG_HP:     r_hp <= i_cfg.data[23:0];
                    REG_REL:    r_rel <= i_cfg.data[23:0];
                    REG_HEAD:   r_head <= i_cfg.data;
                    REG_LA:     r_la <= i_cfg.data[7:0];
                    default:    ;
                endcase
            end
            if (cfg_clear) begin
                r_env <= '0;
                r_wi <= '0;
                r_ri <= '0;
                r_primed <= 1'b0;
            end
            if (i_in.valid && i_in.ready) begin
                r_xl <= i_in.left;
                r_xr <= i_in.right;
            end
            case (r_state)
                S_ENV: r_p <= pk;
                S_REL: r_env <= (r_p > r_env) ? r_p : r_p + rel_rnd[27:0];
                S_WR: begin
                    r_wi <= wi_next[AW-1:0];
                    r_emit <= r_primed;
                    if (!r_primed && wi_next >= la_eff) r_primed <= 1'b1;
                end
                S_OUT: begin
                    r_ol <= r_emit ? lo : '0;
                    r_or <= r_emit ? ro : '0;
                    if (r_emit) r_ri <= (32'(r_ri) + 1 >= DELAY_DEPTH) ? '0 : r_ri + 1'b1;
                    r_ovalid <= 1'b1;
                end
                S_PASS: begin
                    r_ol <= r_xl;
                    r_or <= r_xr;
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    `AST_IMPLY(a_in_idle, i_clk, i_rst_n, i_in.ready, r_state == S_IDLE)
    `AST_NEXT(a_out_set, i_clk, i_rst_n, r_state == S_OUT || r_state == S_PASS, r_ovalid)
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid && $stable(o_out.left) && $stable(o_out.right))
endmodule
